[rtl/cxyk_pkg.sv]
// Package for the CoreXY move kinematics block: defaults, fixed scale constants,
// the sequencer state type and the load/step control bundle. No dependencies.
package cxyk_pkg;

  localparam int unsigned POSITION_BITS_DEF = 24;
  localparam int unsigned FEED_BITS_DEF     = 16;

  // The distance is sqrt(s * 2^FRAC_BITS), so feeds come out scaled by 2^(FRAC_BITS/2).
  localparam int unsigned FRAC_BITS = 16;

  localparam logic KIND_MOVE  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } seq_ctl_t;

endpackage

[rtl/cxyk_isqrt.sv]
// Bit-serial integer square root, one root bit per step (restoring, radix 2).
// Depends on cxyk_pkg for the control bundle.
module cxyk_isqrt #(
  parameter int unsigned ROOT_BITS = 33
) (
  input  logic                      clk_i,
  input  cxyk_pkg::seq_ctl_t        ctl_i,
  input  logic [2*ROOT_BITS-1:0]    radicand_i,
  output logic [ROOT_BITS-1:0]      root_o
);

  logic [2*ROOT_BITS-1:0] rad_q;
  logic [ROOT_BITS-1:0]   root_q;
  logic [ROOT_BITS:0]     rem_q;
  logic [ROOT_BITS+2:0]   cand;
  logic [ROOT_BITS+2:0]   trial;
  logic [ROOT_BITS+2:0]   diff;
  logic                   ge;

  always_comb begin
    cand  = {rem_q, rad_q[2*ROOT_BITS-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
    ge    = (cand >= trial);
    diff  = cand - trial;
  end

  // The remainder never exceeds twice the partial root, so it fits one bit above the root.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      rad_q  <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (ctl_i.step) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? diff[ROOT_BITS:0] : cand[ROOT_BITS:0];
      root_q <= {root_q[ROOT_BITS-2:0], ge};
    end
  end

  assign root_o = root_q;

endmodule

[rtl/cxyk_div.sv]
// Bit-serial restoring divider, one quotient bit per step. The high part of the
// dividend must be below the divisor. Depends on cxyk_pkg for the control bundle.
module cxyk_div #(
  parameter int unsigned REM_BITS  = 33,
  parameter int unsigned QUOT_BITS = 25
) (
  input  logic                  clk_i,
  input  cxyk_pkg::seq_ctl_t    ctl_i,
  input  logic [REM_BITS-2:0]   div_hi_i,
  input  logic [QUOT_BITS-1:0]  div_lo_i,
  input  logic [REM_BITS-1:0]   divisor_i,
  output logic [QUOT_BITS-1:0]  quot_o
);

  logic [REM_BITS-1:0]  rem_q;
  logic [QUOT_BITS-1:0] quot_q;
  logic [REM_BITS:0]    part;
  logic [REM_BITS:0]    diff;
  logic                 ge;

  always_comb begin
    part = {rem_q, quot_q[QUOT_BITS-1]};
    ge   = (part >= {1'b0, divisor_i});
    diff = part - {1'b0, divisor_i};
  end

  // Low dividend bits leave at the top of quot_q while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      rem_q  <= {1'b0, div_hi_i};
      quot_q <= div_lo_i;
    end else if (ctl_i.step) begin
      rem_q  <= ge ? diff[REM_BITS-1:0] : part[REM_BITS-1:0];
      quot_q <= {quot_q[QUOT_BITS-2:0], ge};
    end
  end

  assign quot_o = quot_q;

endmodule

[rtl/corexy_move_kinematics.sv]
// CoreXY move kinematics: motor setpoints and scaled motor feeds for each move.
// Depends on cxyk_pkg, cxyk_isqrt and cxyk_div.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o   | kind, target_x, target_y, feed_rate
//   out     | output    | out_valid_o / out_stall_i | positions A/B, feeds A/B, zero_length
//
// A move runs through serial shift-add squares and products, a sum step, then one root
// bit and one quotient bit per cycle, and a finish step that waits for the output register.
// Reset items and zero-length moves go straight to the finish step. One item is in work at a time;
// the finished result waits in the output register, and a new item may start meanwhile.
// Reset clears the stored point and all control state; no clearing pass is needed.
module corexy_move_kinematics #(
  parameter int unsigned POSITION_BITS = cxyk_pkg::POSITION_BITS_DEF,
  parameter int unsigned FEED_BITS     = cxyk_pkg::FEED_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [POSITION_BITS-1:0]   target_x_i,
  input  logic [POSITION_BITS-1:0]   target_y_i,
  input  logic [FEED_BITS-1:0]       feed_rate_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [POSITION_BITS:0]     motor_a_position_o,
  output logic [POSITION_BITS+1:0]   motor_b_position_o,
  output logic [FEED_BITS+9:0]       motor_a_feed_o,
  output logic [FEED_BITS+9:0]       motor_b_feed_o,
  output logic                       zero_length_o
);

  localparam int P      = POSITION_BITS;
  localparam int FB     = FEED_BITS;
  localparam int FRAC   = cxyk_pkg::FRAC_BITS;
  localparam int ROOTW  = P + FRAC / 2 + 1;
  // Feed magnitudes stay below sqrt(2) * F * 2^8, which needs F + 9 bits.
  localparam int QW     = FB + 9;
  localparam int NUMW   = P + 1;
  localparam int PRODW  = NUMW + FB;
  localparam int DIVW   = PRODW + FRAC;
  localparam int SQW    = 2 * P;
  localparam int SQ_CYC = (P > FB) ? P : FB;
  localparam int MAXC1  = (SQ_CYC > ROOTW) ? SQ_CYC : ROOTW;
  localparam int MAXC   = (MAXC1 > QW) ? MAXC1 : QW;
  localparam int CW     = $clog2(MAXC);
  localparam int OFW    = FB + 10;

  cxyk_pkg::state_e   state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  cxyk_pkg::seq_ctl_t root_ctl, div_ctl;
  logic               sq_step;
  logic               out_load;
  logic               in_acc;
  logic               out_acc;
  logic               out_valid_q;

  logic [P-1:0]       last_x_q, last_y_q;

  // Values formed at accept.
  logic [P:0]         xs, ys, lxs, lys, dx, dy, ndx, ndy;
  logic [P-1:0]       adx, ady;
  logic [P+1:0]       na, nb, nna, nnb;
  logic [NUMW-1:0]    mag_a, mag_b;
  logic [P:0]         pa;
  logic [P+1:0]       pb;
  logic               is_still;

  // Working registers.
  logic [P:0]         pos_a_q;
  logic [P+1:0]       pos_b_q;
  logic               sign_a_q, sign_b_q, zero_q, no_feed_q;
  logic [SQW-1:0]     mcx_q, mcy_q, accx_q, accy_q;
  logic [P-1:0]       mrx_q, mry_q;
  logic [PRODW-1:0]   mca_q, mcb_q, acca_q, accb_q;
  logic [FB-1:0]      mrf_q;

  logic [SQW:0]       sq_sum;
  logic [2*ROOTW-1:0] radicand;
  logic [DIVW-1:0]    dividend_a, dividend_b;
  logic [ROOTW-1:0]   dist_root;
  logic [QW-1:0]      quot_a, quot_b;
  logic [OFW-1:0]     fmag_a, fmag_b, feed_a, feed_b;

  assign in_stall_o  = (state_q != cxyk_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    xs  = {target_x_i[P-1], target_x_i};
    ys  = {target_y_i[P-1], target_y_i};
    lxs = {last_x_q[P-1], last_x_q};
    lys = {last_y_q[P-1], last_y_q};
    dx  = xs - lxs;
    dy  = ys - lys;
    ndx = -dx;
    ndy = -dy;
    adx = dx[P] ? ndx[P-1:0] : dx[P-1:0];
    ady = dy[P] ? ndy[P-1:0] : dy[P-1:0];
    na  = {dx[P], dx} - {dy[P], dy};
    nb  = -{dx[P], dx} - {dy[P], dy};
    nna = -na;
    nnb = -nb;
    mag_a = na[P+1] ? nna[P:0] : na[P:0];
    mag_b = nb[P+1] ? nnb[P:0] : nb[P:0];
    pa  = xs - ys;
    pb  = -{xs[P], xs} - {ys[P], ys};
    is_still = (dx == '0) && (dy == '0);
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cxyk_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      last_x_q    <= '0;
      last_y_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        if (kind_i == cxyk_pkg::KIND_RESET) begin
          last_x_q <= '0;
          last_y_q <= '0;
        end else begin
          last_x_q <= target_x_i;
          last_y_q <= target_y_i;
        end
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    root_ctl = '0;
    div_ctl  = '0;
    sq_step  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      cxyk_pkg::ST_IDLE: begin
        if (in_acc) begin
          if ((kind_i == cxyk_pkg::KIND_RESET) || is_still) begin
            state_d = cxyk_pkg::ST_FINISH;
          end else begin
            state_d = cxyk_pkg::ST_SQUARE;
            cnt_d   = CW'(SQ_CYC - 1);
          end
        end
      end
      cxyk_pkg::ST_SQUARE: begin
        sq_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = cxyk_pkg::ST_SUM;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      cxyk_pkg::ST_SUM: begin
        root_ctl.load = 1'b1;
        div_ctl.load  = 1'b1;
        cnt_d         = CW'(ROOTW - 1);
        state_d       = cxyk_pkg::ST_ROOT;
      end
      cxyk_pkg::ST_ROOT: begin
        root_ctl.step = 1'b1;
        if (cnt_q == '0) begin
          state_d = cxyk_pkg::ST_DIVIDE;
          cnt_d   = CW'(QW - 1);
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      cxyk_pkg::ST_DIVIDE: begin
        div_ctl.step = 1'b1;
        if (cnt_q == '0) begin
          state_d = cxyk_pkg::ST_FINISH;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      cxyk_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = cxyk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cxyk_pkg::ST_IDLE;
      end
    endcase
  end

  // Item registers and the shift-add squares and products, one multiplier bit a cycle.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sign_a_q  <= na[P+1];
      sign_b_q  <= nb[P+1];
      mcx_q     <= {{P{1'b0}}, adx};
      mcy_q     <= {{P{1'b0}}, ady};
      mrx_q     <= adx;
      mry_q     <= ady;
      accx_q    <= '0;
      accy_q    <= '0;
      mca_q     <= {{FB{1'b0}}, mag_a};
      mcb_q     <= {{FB{1'b0}}, mag_b};
      mrf_q     <= feed_rate_i;
      acca_q    <= '0;
      accb_q    <= '0;
      if (kind_i == cxyk_pkg::KIND_RESET) begin
        pos_a_q   <= '0;
        pos_b_q   <= '0;
        zero_q    <= 1'b0;
        no_feed_q <= 1'b1;
      end else begin
        pos_a_q   <= pa;
        pos_b_q   <= pb;
        zero_q    <= is_still;
        no_feed_q <= is_still;
      end
    end else if (sq_step) begin
      accx_q <= accx_q + (mrx_q[0] ? mcx_q : '0);
      accy_q <= accy_q + (mry_q[0] ? mcy_q : '0);
      mcx_q  <= mcx_q << 1;
      mcy_q  <= mcy_q << 1;
      mrx_q  <= mrx_q >> 1;
      mry_q  <= mry_q >> 1;
      acca_q <= acca_q + (mrf_q[0] ? mca_q : '0);
      accb_q <= accb_q + (mrf_q[0] ? mcb_q : '0);
      mca_q  <= mca_q << 1;
      mcb_q  <= mcb_q << 1;
      mrf_q  <= mrf_q >> 1;
    end
  end

  always_comb begin
    sq_sum     = {1'b0, accx_q} + {1'b0, accy_q};
    radicand   = {1'b0, sq_sum, {FRAC{1'b0}}};
    dividend_a = {acca_q, {FRAC{1'b0}}};
    dividend_b = {accb_q, {FRAC{1'b0}}};
  end

  cxyk_isqrt #(
    .ROOT_BITS (ROOTW)
  ) u_isqrt (
    .clk_i      (clk_i),
    .ctl_i      (root_ctl),
    .radicand_i (radicand),
    .root_o     (dist_root)
  );

  cxyk_div #(
    .REM_BITS  (ROOTW),
    .QUOT_BITS (QW)
  ) u_div_a (
    .clk_i     (clk_i),
    .ctl_i     (div_ctl),
    .div_hi_i  (dividend_a[DIVW-1:QW]),
    .div_lo_i  (dividend_a[QW-1:0]),
    .divisor_i (dist_root),
    .quot_o    (quot_a)
  );

  cxyk_div #(
    .REM_BITS  (ROOTW),
    .QUOT_BITS (QW)
  ) u_div_b (
    .clk_i     (clk_i),
    .ctl_i     (div_ctl),
    .div_hi_i  (dividend_b[DIVW-1:QW]),
    .div_lo_i  (dividend_b[QW-1:0]),
    .divisor_i (dist_root),
    .quot_o    (quot_b)
  );

  always_comb begin
    fmag_a = {1'b0, quot_a};
    fmag_b = {1'b0, quot_b};
    feed_a = no_feed_q ? '0 : (sign_a_q ? -fmag_a : fmag_a);
    feed_b = no_feed_q ? '0 : (sign_b_q ? -fmag_b : fmag_b);
  end

  // Output register: holds a finished result until its transfer completes.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      motor_a_position_o <= pos_a_q;
      motor_b_position_o <= pos_b_q;
      motor_a_feed_o     <= feed_a;
      motor_b_feed_o     <= feed_b;
      zero_length_o      <= zero_q;
    end
  end

endmodule

[tb/sv/cxyk_setpoint_check.sv]
// Setpoint checker for the CoreXY move kinematics block: predicts each result from the
// accepted move and reset items and compares it with the block's output transfers.
// Depends on cxyk_pkg for the default widths and the item kind codes.
module cxyk_setpoint_check (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  input  logic                                       in_stall_i,
  input  logic                                       kind_i,
  input  logic [cxyk_pkg::POSITION_BITS_DEF-1:0]     target_x_i,
  input  logic [cxyk_pkg::POSITION_BITS_DEF-1:0]     target_y_i,
  input  logic [cxyk_pkg::FEED_BITS_DEF-1:0]         feed_rate_i,
  input  logic                                       out_valid_i,
  input  logic                                       out_stall_i,
  input  logic [cxyk_pkg::POSITION_BITS_DEF:0]       motor_a_position_i,
  input  logic [cxyk_pkg::POSITION_BITS_DEF+1:0]     motor_b_position_i,
  input  logic [cxyk_pkg::FEED_BITS_DEF+9:0]         motor_a_feed_i,
  input  logic [cxyk_pkg::FEED_BITS_DEF+9:0]         motor_b_feed_i,
  input  logic                                       zero_length_i,
  output int unsigned                                mismatch_count_o,
  output int unsigned                                pending_o
);

  localparam int PB = cxyk_pkg::POSITION_BITS_DEF;
  localparam int FB = cxyk_pkg::FEED_BITS_DEF;

  typedef struct packed {
    logic signed [PB:0]   pos_a;
    logic signed [PB+1:0] pos_b;
    logic signed [FB+9:0] feed_a;
    logic signed [FB+9:0] feed_b;
    logic                 zero_len;
  } setpoint_t;

  logic signed [PB-1:0] prev_x;
  logic signed [PB-1:0] prev_y;
  setpoint_t            expected_setpoints[$];
  setpoint_t            oldest;
  int unsigned          bad_fields;

  assign mismatch_count_o = bad_fields;
  assign pending_o        = expected_setpoints.size();

  // Integer square root of sq * 2^16, one result bit per pass over bit pairs.
  function automatic longint unsigned q8_distance(input longint unsigned sq);
    logic [65:0] rad;
    logic [67:0] rem;
    logic [67:0] trial;
    logic [33:0] root;
    rad  = {sq[49:0], 16'h0000};
    rem  = '0;
    root = '0;
    for (int k = 32; k >= 0; k--) begin
      rem   = (rem << 2) | 68'((rad >> (2 * k)) & 66'd3);
      trial = (68'(root) << 2) | 68'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 34'd1;
      end else begin
        root = root << 1;
      end
    end
    return longint'(root);
  endfunction

  // Feed component scaled by 2^16 over the Q.8 distance, truncated toward zero.
  function automatic longint scaled_feed(input longint num, input logic [FB-1:0] rate,
                                         input longint unsigned dist_q8);
    longint unsigned mag;
    longint unsigned quot;
    mag  = (num < 0) ? longint'(-num) : longint'(num);
    quot = ((mag * rate) << 16) / dist_q8;
    return (num < 0) ? -longint'(quot) : longint'(quot);
  endfunction

  function automatic setpoint_t predict_setpoint(input logic kind,
                                                 input logic signed [PB-1:0] tx,
                                                 input logic signed [PB-1:0] ty,
                                                 input logic [FB-1:0] rate);
    setpoint_t       sp;
    longint          dx;
    longint          dy;
    longint unsigned adx;
    longint unsigned ady;
    longint unsigned sq_sum;
    longint unsigned dist_q8;
    sp = '0;
    if (kind == cxyk_pkg::KIND_RESET) begin
      prev_x = '0;
      prev_y = '0;
      return sp;
    end
    sp.pos_a = (PB+1)'(longint'(tx) - longint'(ty));
    sp.pos_b = (PB+2)'(-longint'(tx) - longint'(ty));
    dx     = longint'(tx) - longint'(prev_x);
    dy     = longint'(ty) - longint'(prev_y);
    adx    = (dx < 0) ? longint'(-dx) : longint'(dx);
    ady    = (dy < 0) ? longint'(-dy) : longint'(dy);
    sq_sum = adx * adx + ady * ady;
    if (sq_sum == 0) begin
      sp.zero_len = 1'b1;
    end else begin
      dist_q8   = q8_distance(sq_sum);
      sp.feed_a = (FB+10)'(scaled_feed(dx - dy, rate, dist_q8));
      sp.feed_b = (FB+10)'(scaled_feed(-dx - dy, rate, dist_q8));
    end
    prev_x = tx;
    prev_y = ty;
    return sp;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad_fields++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x     = '0;
      prev_y     = '0;
      bad_fields = 0;
      expected_setpoints.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_setpoints.push_back(predict_setpoint(kind_i, target_x_i, target_y_i,
                                                      feed_rate_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_setpoints.size() == 0) begin
          $error("result transfer with no move outstanding");
          bad_fields++;
        end else begin
          oldest = expected_setpoints.pop_front();
          check_field("motor_a_position", 64'(oldest.pos_a),
                      64'($signed(motor_a_position_i)));
          check_field("motor_b_position", 64'(oldest.pos_b),
                      64'($signed(motor_b_position_i)));
          check_field("motor_a_feed", 64'(oldest.feed_a), 64'($signed(motor_a_feed_i)));
          check_field("motor_b_feed", 64'(oldest.feed_b), 64'($signed(motor_b_feed_i)));
          check_field("zero_length", 64'(oldest.zero_len), 64'(zero_length_i));
        end
      end
    end
  end

endmodule

[tb/sv/corexy_move_kinematics_tb.sv]
// Top of the CoreXY move kinematics testbench: drives move and reset items with random
// gaps and output stalls, and gives the verdict. Depends on cxyk_pkg, the block and
// cxyk_setpoint_check.
module corexy_move_kinematics_tb;

  localparam int PB = cxyk_pkg::POSITION_BITS_DEF;
  localparam int FB = cxyk_pkg::FEED_BITS_DEF;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 kind_i      = cxyk_pkg::KIND_MOVE;
  logic [PB-1:0]        target_x_i  = '0;
  logic [PB-1:0]        target_y_i  = '0;
  logic [FB-1:0]        feed_rate_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PB:0]          motor_a_position_o;
  logic [PB+1:0]        motor_b_position_o;
  logic [FB+9:0]        motor_a_feed_o;
  logic [FB+9:0]        motor_b_feed_o;
  logic                 zero_length_o;

  int unsigned          mismatch_count;
  int unsigned          pending_results;
  bit                   quiet_stretch = 1'b0;
  logic signed [PB-1:0] cursor_x = '0;
  logic signed [PB-1:0] cursor_y = '0;

  corexy_move_kinematics uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .target_x_i         (target_x_i),
    .target_y_i         (target_y_i),
    .feed_rate_i        (feed_rate_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .motor_a_position_o (motor_a_position_o),
    .motor_b_position_o (motor_b_position_o),
    .motor_a_feed_o     (motor_a_feed_o),
    .motor_b_feed_o     (motor_b_feed_o),
    .zero_length_o      (zero_length_o)
  );

  cxyk_setpoint_check u_setpoint_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .kind_i             (kind_i),
    .target_x_i         (target_x_i),
    .target_y_i         (target_y_i),
    .feed_rate_i        (feed_rate_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .motor_a_position_i (motor_a_position_o),
    .motor_b_position_i (motor_b_position_o),
    .motor_a_feed_i     (motor_a_feed_o),
    .motor_b_feed_i     (motor_b_feed_o),
    .zero_length_i      (zero_length_o),
    .mismatch_count_o   (mismatch_count),
    .pending_o          (pending_results)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !quiet_stretch && ($urandom_range(99) < 38);
  end

  initial begin
    #20000000;
    $display("Regression FAIL");
    $finish;
  end

  // The payload stays put while the transfer is stalled; the stored point follows the
  // accepted item so that zero-length and short moves can be aimed at it.
  task automatic send_item(input logic kind, input logic signed [PB-1:0] x,
                           input logic signed [PB-1:0] y, input logic [FB-1:0] rate);
    while (!quiet_stretch && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    target_x_i  <= x;
    target_y_i  <= y;
    feed_rate_i <= rate;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (kind == cxyk_pkg::KIND_RESET) begin
      cursor_x = '0;
      cursor_y = '0;
    end else begin
      cursor_x = x;
      cursor_y = y;
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [PB-1:0] corner_coord();
    unique case ($urandom_range(3))
      0:       return {1'b1, {(PB-1){1'b0}}};
      1:       return {1'b0, {(PB-1){1'b1}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  initial begin
    logic signed [PB-1:0] pos_min;
    logic signed [PB-1:0] pos_max;
    logic signed [PB-1:0] step_x;
    logic signed [PB-1:0] step_y;
    logic signed [PB-1:0] nx;
    logic signed [PB-1:0] ny;
    logic [FB-1:0]        rate;
    logic                 kind;
    int unsigned          pick;

    pos_min = {1'b1, {(PB-1){1'b0}}};
    pos_max = {1'b0, {(PB-1){1'b1}}};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero-length from home, zero feed, the longest diagonals, reset items.
    send_item(cxyk_pkg::KIND_MOVE, PB'(0), PB'(0), 16'd1000);
    send_item(cxyk_pkg::KIND_MOVE, PB'(100), PB'(0), 16'd1000);
    send_item(cxyk_pkg::KIND_MOVE, PB'(100), PB'(0), 16'hFFFF);
    send_item(cxyk_pkg::KIND_MOVE, PB'(100), PB'(200), 16'd0);
    send_item(cxyk_pkg::KIND_MOVE, pos_min, pos_max, 16'hFFFF);
    send_item(cxyk_pkg::KIND_MOVE, pos_max, pos_min, 16'hFFFF);
    send_item(cxyk_pkg::KIND_MOVE, pos_min, pos_min, 16'hFFFF);
    send_item(cxyk_pkg::KIND_MOVE, pos_max, pos_max, 16'hFFFF);
    send_item(cxyk_pkg::KIND_MOVE, pos_max, pos_max, 16'd1);
    send_item(cxyk_pkg::KIND_RESET, 24'h5A5A5A, 24'hA5A5A5, 16'hA5A5);
    send_item(cxyk_pkg::KIND_MOVE, PB'(1), PB'(0), 16'hFFFF);
    send_item(cxyk_pkg::KIND_MOVE, PB'(1), PB'(1), 16'd1);
    send_item(cxyk_pkg::KIND_MOVE, PB'(0), PB'(0), 16'hFFFF);
    send_item(cxyk_pkg::KIND_RESET, pos_max, pos_min, 16'hFFFF);
    send_item(cxyk_pkg::KIND_RESET, '1, '1, 16'd0);
    send_item(cxyk_pkg::KIND_MOVE, PB'(-1), PB'(-1), 16'hFFFF);
    send_item(cxyk_pkg::KIND_MOVE, pos_min, PB'(0), 16'd12345);
    send_item(cxyk_pkg::KIND_MOVE, PB'(0), pos_max, 16'hFFFF);
    send_item(cxyk_pkg::KIND_MOVE, PB'(0), pos_max, 16'hFFFF);
    send_item(cxyk_pkg::KIND_MOVE, pos_min, pos_min, 16'h8000);
    drain_results();

    for (int n = 0; n < 1450; n++) begin
      quiet_stretch = (n >= 500) && (n < 700);
      if (n % 250 == 249) drain_results();
      pick = $urandom_range(99);
      kind = cxyk_pkg::KIND_MOVE;
      step_x = PB'(int'($urandom_range(64)) - 32);
      step_y = PB'(int'($urandom_range(64)) - 32);
      if (pick < 8) begin
        kind = cxyk_pkg::KIND_RESET;
        nx   = PB'($urandom());
        ny   = PB'($urandom());
      end else if (pick < 20) begin
        nx = cursor_x;
        ny = cursor_y;
      end else if (pick < 50) begin
        nx = cursor_x + step_x;
        ny = cursor_y + step_y;
      end else if (pick < 62) begin
        nx = corner_coord();
        ny = corner_coord();
      end else begin
        nx = PB'($urandom());
        ny = PB'($urandom());
      end
      pick = $urandom_range(99);
      if (pick < 6) rate = '0;
      else if (pick < 14) rate = '1;
      else rate = FB'($urandom_range(65535));
      send_item(kind, nx, ny, rate);
    end
    quiet_stretch = 1'b0;

    drain_results();
    repeat (120) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
